FILE: sv/rts_pkg.sv
// Shared constants for the resistive touch scanner and its port checker.
// No dependencies.
package rts_pkg;

  localparam int SAMPLE_W = 12;
  localparam int HOLD_W   = 8;
  localparam int SX_W     = 8;
  localparam int SY_W     = 9;
  localparam int FULL_W   = 9;
  localparam int PROD_W   = SAMPLE_W + FULL_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [FULL_W-1:0] X_FULL = FULL_W'(239);
  localparam logic [FULL_W-1:0] Y_FULL = FULL_W'(319);

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_CLICK   = 2'd1;
  localparam logic [1:0] EV_DRAG    = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  localparam logic [1:0] HIST_CLICK   = 2'b01;
  localparam logic [1:0] HIST_DRAG    = 2'b11;
  localparam logic [1:0] HIST_RELEASE = 2'b10;

  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd4;

endpackage

FILE: sv/resistive_touch_scanner.sv
// Four-wire resistive touch scanner: phase sequencer, touch history and
// a shared multiply / serial-divide unit for coordinate scaling. Uses rts_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | adc_sample
//  output   | out_valid / out_stall  | drive_axis, touch_event, screen_x, screen_y
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Start, read and non-scaling classify items are written straight to the output register.
// A click or an unsuppressed drag is scaled per axis, X then Y: offset and span,
// the 12x9 multiply, nine restoring divide steps, then a store.
// in_stall is high while the scaling unit runs or a result waits on out_stall.
// Synchronous reset restores limits and the start phase; cfg_ready is always high.
module resistive_touch_scanner
  import rts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  adc_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 drive_axis,
  output logic [1:0]           touch_event,
  output logic [SX_W-1:0]      screen_x,
  output logic [SY_W-1:0]      screen_y,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    PH_START    = 4'b0001,
    PH_READ_X   = 4'b0010,
    PH_READ_Y   = 4'b0100,
    PH_CLASSIFY = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'b0001,
    SEQ_PREP  = 4'b0010,
    SEQ_MUL   = 4'b0100,
    SEQ_DIV   = 4'b1000
  } seq_t;

  // configuration
  logic [SAMPLE_W-1:0] x_high, x_low, y_high, y_low;
  logic [HOLD_W-1:0]   hold;

  // scan state
  phase_t              phase;
  logic [SAMPLE_W-1:0] raw_x, raw_y;
  logic [1:0]          hist;
  logic [HOLD_W-1:0]   countdown;
  logic [SX_W-1:0]     last_x;
  logic [SY_W-1:0]     last_y;

  // scaling unit
  seq_t                seq;
  logic                ax;        // 0 while scaling X, 1 while scaling Y
  logic                store;     // last divide step done, result ready
  logic [1:0]          ev_pend;
  logic [SAMPLE_W-1:0] off, span, rem;
  logic [FULL_W-1:0]   quo;
  logic                zero, sat;
  logic [3:0]          cnt;

  logic                in_acc, out_acc, touched;
  logic [SAMPLE_W-1:0] sel_sample, sel_low, sel_high;
  logic [FULL_W-1:0]   sel_full, res;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W:0]   trial, trial_sub;
  logic                trial_ge;

  assign cfg_ready = 1'b1;
  assign in_stall  = (seq != SEQ_IDLE) || store || (out_valid && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign touched = (raw_x <= x_high) && (raw_x >= x_low) &&
                   (adc_sample <= y_high) && (adc_sample >= y_low);

  always_comb begin
    sel_sample = ax ? raw_y : raw_x;
    sel_low    = ax ? y_low : x_low;
    sel_high   = ax ? y_high : x_high;
    sel_full   = ax ? Y_FULL : X_FULL;
    prod       = PROD_W'(off) * PROD_W'(sel_full);
    trial      = {rem, quo[FULL_W-1]};
    trial_ge   = trial >= {1'b0, span};
    trial_sub  = trial - {1'b0, span};
    if (zero) begin
      res = '0;
    end else if (sat) begin
      res = sel_full;
    end else begin
      res = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_high    <= '1;
      x_low     <= '0;
      y_high    <= '1;
      y_low     <= '0;
      hold      <= HOLD_W'(4);
      phase     <= PH_START;
      raw_x     <= '0;
      raw_y     <= '0;
      hist      <= '0;
      countdown <= '0;
      last_x    <= '0;
      last_y    <= '0;
      seq       <= SEQ_IDLE;
      store     <= 1'b0;
      ax        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_HIGH: x_high <= cfg_data;
          REG_X_LOW:  x_low  <= cfg_data;
          REG_Y_HIGH: y_high <= cfg_data;
          REG_Y_LOW:  y_low  <= cfg_data;
          REG_HOLD:   hold   <= cfg_data[HOLD_W-1:0];
          default: ;
        endcase
      end

      if (out_acc) begin
        out_valid <= 1'b0;
      end

      if (in_acc) begin
        case (phase)
          PH_READ_X: begin
            raw_x       <= adc_sample;
            phase       <= PH_READ_Y;
            out_valid   <= 1'b1;
            drive_axis  <= 1'b1;
            touch_event <= EV_NONE;
            screen_x    <= '0;
            screen_y    <= '0;
          end
          PH_READ_Y: begin
            raw_y       <= adc_sample;
            hist        <= {hist[0], touched};
            phase       <= PH_CLASSIFY;
            out_valid   <= 1'b1;
            drive_axis  <= 1'b0;
            touch_event <= EV_NONE;
            screen_x    <= '0;
            screen_y    <= '0;
          end
          PH_CLASSIFY: begin
            phase      <= PH_READ_X;
            drive_axis <= 1'b0;
            case (hist)
              HIST_CLICK: begin
                countdown <= hold;
                ev_pend   <= EV_CLICK;
                ax        <= 1'b0;
                seq       <= SEQ_PREP;
              end
              HIST_DRAG: begin
                if (countdown != '0) begin
                  countdown   <= countdown - HOLD_W'(1);
                  out_valid   <= 1'b1;
                  touch_event <= EV_NONE;
                  screen_x    <= '0;
                  screen_y    <= '0;
                end else begin
                  ev_pend <= EV_DRAG;
                  ax      <= 1'b0;
                  seq     <= SEQ_PREP;
                end
              end
              HIST_RELEASE: begin
                out_valid   <= 1'b1;
                touch_event <= EV_RELEASE;
                screen_x    <= last_x;
                screen_y    <= last_y;
              end
              default: begin
                out_valid   <= 1'b1;
                touch_event <= EV_NONE;
                screen_x    <= '0;
                screen_y    <= '0;
              end
            endcase
          end
          default: begin
            phase       <= PH_READ_X;
            out_valid   <= 1'b1;
            drive_axis  <= 1'b0;
            touch_event <= EV_NONE;
            screen_x    <= '0;
            screen_y    <= '0;
          end
        endcase
      end

      // shared scaling unit
      if (store) begin
        store <= 1'b0;
        if (!ax) begin
          last_x <= res[SX_W-1:0];
          ax     <= 1'b1;
          seq    <= SEQ_PREP;
        end else begin
          last_y      <= res;
          out_valid   <= 1'b1;
          touch_event <= ev_pend;
          screen_x    <= last_x;
          screen_y    <= res;
        end
      end

      case (seq)
        SEQ_PREP: begin
          off  <= (sel_sample > sel_low) ? sel_sample - sel_low : '0;
          span <= (sel_high > sel_low) ? sel_high - sel_low : '0;
          seq  <= SEQ_MUL;
        end
        SEQ_MUL: begin
          // offset below span keeps the quotient under the full scale
          rem  <= prod[PROD_W-1:FULL_W];
          quo  <= prod[FULL_W-1:0];
          zero <= span == '0;
          sat  <= off >= span;
          cnt  <= '0;
          seq  <= SEQ_DIV;
        end
        SEQ_DIV: begin
          rem <= trial_ge ? trial_sub[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
          quo <= {quo[FULL_W-2:0], trial_ge};
          cnt <= cnt + 4'd1;
          if (cnt == 4'(FULL_W - 1)) begin
            seq   <= SEQ_IDLE;
            store <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/rts_checker.sv
// Port-level checker for resistive_touch_scanner, bound into that module.
// Uses rts_pkg for event codes and full-scale limits.
module rts_checker
  import rts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 drive_axis,
  input logic [1:0]           touch_event,
  input logic [SX_W-1:0]      screen_x,
  input logic [SY_W-1:0]      screen_y
);

  // a result without an event carries zero coordinates
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && touch_event == EV_NONE |-> screen_x == '0 && screen_y == '0)
    else $error("coordinates set without an event");

  // coordinates never exceed the screen
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> screen_x <= SX_W'(X_FULL) && screen_y <= Y_FULL)
    else $error("coordinate beyond full scale");

  // events are reported only on the classify transfer, which drives X
  a_event_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_axis |-> touch_event == EV_NONE)
    else $error("event reported while driving Y");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(touch_event) &&
      $stable(screen_x) && $stable(screen_y) && $stable(drive_axis))
    else $error("stalled result changed");

endmodule

bind resistive_touch_scanner rts_checker u_rts_checker (.*);

FILE: tb/tb_resistive_touch_scanner.sv
// Testbench for resistive_touch_scanner: a directed table, then random touch scans
// under random limits, each result checked against the table's expected report or an in-bench scan predictor.
// Depends on rts_pkg and the scanner RTL only.
module tb_resistive_touch_scanner
  import rts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PHASE_START, PHASE_READ_X, PHASE_READ_Y, PHASE_CLASSIFY
  } scan_phase_t;

  typedef struct packed {
    logic            axis;
    logic [1:0]      ev;
    logic [SX_W-1:0] sx;
    logic [SY_W-1:0] sy;
  } scan_report_t;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [SAMPLE_W-1:0]  value;
    logic                 known;
    scan_report_t         report;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  adc_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 drive_axis;
  logic [1:0]           touch_event;
  logic [SX_W-1:0]      screen_x;
  logic [SY_W-1:0]      screen_y;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0]  cfg_data = '0;

  // Predictor copy of the limits and scan state
  logic [SAMPLE_W-1:0] lim_x_hi = '1, lim_x_lo = '0, lim_y_hi = '1, lim_y_lo = '0;
  logic [HOLD_W-1:0]   drag_hold = 8'd4;
  scan_phase_t         sc_phase = PHASE_START;
  logic [SAMPLE_W-1:0] sc_raw_x = '0, sc_raw_y = '0;
  logic [1:0]          sc_hist = '0;
  logic [HOLD_W-1:0]   sc_hold_count = '0;
  logic [SX_W-1:0]     sc_last_x = '0;
  logic [SY_W-1:0]     sc_last_y = '0;

  scan_report_t expected_reports[$];
  stim_row_t    directed_rows[$];
  int           errors = 0;
  logic         steady = 1'b0;
  logic         pressed = 1'b0;

  resistive_touch_scanner dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [FULL_W-1:0] scale_coord(input logic [SAMPLE_W-1:0] s, lo, hi,
                                                    input logic [FULL_W-1:0] full);
    logic [SAMPLE_W-1:0] offset, span;
    logic [PROD_W-1:0]   quot;
    offset = (s > lo) ? s - lo : '0;
    span = (hi > lo) ? hi - lo : '0;
    if (span == '0) return '0;
    quot = (PROD_W'(offset) * PROD_W'(full)) / PROD_W'(span);
    return (quot > PROD_W'(full)) ? full : quot[FULL_W-1:0];
  endfunction

  function automatic scan_report_t predict_report(input logic [SAMPLE_W-1:0] s);
    scan_report_t r;
    logic         touched;
    logic         rescale;
    r = '0;
    rescale = 1'b0;
    case (sc_phase)
      PHASE_START: sc_phase = PHASE_READ_X;
      PHASE_READ_X: begin
        sc_raw_x = s;
        r.axis = 1'b1;
        sc_phase = PHASE_READ_Y;
      end
      PHASE_READ_Y: begin
        sc_raw_y = s;
        touched = sc_raw_x <= lim_x_hi && sc_raw_x >= lim_x_lo &&
                  sc_raw_y <= lim_y_hi && sc_raw_y >= lim_y_lo;
        sc_hist = {sc_hist[0], touched};
        sc_phase = PHASE_CLASSIFY;
      end
      default: begin
        if (sc_hist == HIST_CLICK) begin
          rescale = 1'b1;
          sc_hold_count = drag_hold;
          r.ev = EV_CLICK;
        end else if (sc_hist == HIST_DRAG) begin
          // hold off drag reports until the countdown runs out
          if (sc_hold_count != '0) begin
            sc_hold_count = sc_hold_count - 1'b1;
          end else begin
            rescale = 1'b1;
            r.ev = EV_DRAG;
          end
        end else if (sc_hist == HIST_RELEASE) begin
          r.ev = EV_RELEASE;
        end
        if (rescale) begin
          sc_last_x = SX_W'(scale_coord(sc_raw_x, lim_x_lo, lim_x_hi, X_FULL));
          sc_last_y = SY_W'(scale_coord(sc_raw_y, lim_y_lo, lim_y_hi, Y_FULL));
        end
        if (r.ev != EV_NONE) begin
          r.sx = sc_last_x;
          r.sy = sc_last_y;
        end
        sc_phase = PHASE_READ_X;
      end
    endcase
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] lo, hi,
                                                      input logic in_win);
    if (in_win && lo <= hi) begin
      case ($urandom_range(7))
        0: return lo;
        1: return hi;
        default: return SAMPLE_W'($urandom_range(hi, lo));
      endcase
    end
    if (lo > 0 && (hi == '1 || $urandom_range(1) == 0))
      return SAMPLE_W'($urandom_range(lo - 1, 0));
    if (hi < '1) return SAMPLE_W'($urandom_range(4095, hi + 1));
    return SAMPLE_W'($urandom_range(4095, 0));
  endfunction

  task automatic pick_window(output logic [SAMPLE_W-1:0] lo, hi);
    case ($urandom_range(5))
      0: begin
        lo = '0;
        hi = '1;
      end
      1: begin
        lo = SAMPLE_W'($urandom_range(4095, 0));
        hi = lo;
      end
      2: begin
        hi = SAMPLE_W'($urandom_range(4094, 0));
        lo = SAMPLE_W'($urandom_range(4095, hi + 1));
      end
      3: begin
        lo = '0;
        hi = SAMPLE_W'($urandom_range(4095, 0));
      end
      4: begin
        lo = SAMPLE_W'($urandom_range(4095, 0));
        hi = '1;
      end
      default: begin
        lo = SAMPLE_W'($urandom_range(3000, 0));
        hi = SAMPLE_W'($urandom_range(4095, lo));
      end
    endcase
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.value = value;
    row.known = 1'b0;
    row.report = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_item(input logic [SAMPLE_W-1:0] value, input logic known,
                          input logic axis, input logic [1:0] ev,
                          input logic [SX_W-1:0] sx, input logic [SY_W-1:0] sy);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.value = value;
    row.known = known;
    row.report.axis = axis;
    row.report.ev = ev;
    row.report.sx = sx;
    row.report.sy = sy;
    directed_rows.push_back(row);
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                             input scan_report_t typed);
    int           gap;
    scan_report_t r;
    gap = 0;
    if (!steady) while ($urandom_range(99) < 34) gap++;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sample <= s;
    do @(posedge clk); while (in_stall);
    r = predict_report(s);
    expected_reports.push_back(known ? typed : r);
  endtask

  // Drain all pending results before touching a register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_HIGH: lim_x_hi = value;
      REG_X_LOW:  lim_x_lo = value;
      REG_Y_HIGH: lim_y_hi = value;
      REG_Y_LOW:  lim_y_lo = value;
      REG_HOLD:   drag_hold = value[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    scan_report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected transfer: axis %0d event %0d x %0d y %0d",
                   $time, drive_axis, touch_event, screen_x, screen_y);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (drive_axis !== want.axis) begin
            $display("%0t: drive_axis expected %0d, got %0d", $time, want.axis, drive_axis);
            errors++;
          end
          if (touch_event !== want.ev) begin
            $display("%0t: touch_event expected %0d, got %0d", $time, want.ev, touch_event);
            errors++;
          end
          if (screen_x !== want.sx) begin
            $display("%0t: screen_x expected %0d, got %0d", $time, want.sx, screen_x);
            errors++;
          end
          if (screen_y !== want.sy) begin
            $display("%0t: screen_y expected %0d, got %0d", $time, want.sy, screen_y);
            errors++;
          end
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 34);
    end
  end

  initial begin
    int                  ph;
    int                  n;
    logic [SAMPLE_W-1:0] s;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Click then immediate drag at full range
    add_cfg(REG_HOLD, 12'd0);
    add_item(12'hFFF, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'hFFF, 1'b1, 1'b1, EV_NONE, 0, 0);
    add_item(12'hFFF, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'hFFF, 1'b1, 1'b0, EV_CLICK, 239, 319);
    add_item(12'h000, 1'b1, 1'b1, EV_NONE, 0, 0);
    add_item(12'h000, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'h000, 1'b1, 1'b0, EV_DRAG, 0, 0);
    // Zero-width X window: drag scales X to zero, then release and idle scan
    add_cfg(REG_X_HIGH, 12'd2048);
    add_cfg(REG_X_LOW, 12'd2048);
    add_item(12'd2048, 1'b1, 1'b1, EV_NONE, 0, 0);
    add_item(12'hFFF, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'h5A5, 1'b1, 1'b0, EV_DRAG, 0, 319);
    add_item(12'd2049, 1'b1, 1'b1, EV_NONE, 0, 0);
    add_item(12'h000, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'hA5A, 1'b1, 1'b0, EV_RELEASE, 0, 319);
    add_item(12'h000, 1'b1, 1'b1, EV_NONE, 0, 0);
    add_item(12'h000, 1'b1, 1'b0, EV_NONE, 0, 0);
    add_item(12'h000, 1'b1, 1'b0, EV_NONE, 0, 0);
    // Narrow Y window with the longest drag hold
    add_cfg(REG_X_LOW, 12'd0);
    add_cfg(REG_X_HIGH, 12'hFFF);
    add_cfg(REG_Y_HIGH, 12'd1100);
    add_cfg(REG_Y_LOW, 12'd100);
    add_cfg(REG_HOLD, 12'hFFF);
    add_item(12'hFFF, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'd600, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'h123, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'd17, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'd1100, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'hFFF, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'd3000, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'd99, 1'b0, 1'b0, EV_NONE, 0, 0);
    add_item(12'h000, 1'b0, 1'b0, EV_NONE, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_reg(directed_rows[i].idx, directed_rows[i].value);
      else send_sample(directed_rows[i].value, directed_rows[i].known, directed_rows[i].report);
    end

    for (ph = 0; ph < 12; ph++) begin
      steady = (ph == 5 || ph == 6);
      pick_window(lo, hi);
      write_reg(REG_X_HIGH, hi);
      write_reg(REG_X_LOW, lo);
      pick_window(lo, hi);
      write_reg(REG_Y_HIGH, hi);
      write_reg(REG_Y_LOW, lo);
      case ($urandom_range(7))
        0: s = 12'd0;
        1: s = 12'd255;
        default: s = SAMPLE_W'($urandom_range(6, 1));
      endcase
      write_reg(REG_HOLD, {4'($urandom), s[7:0]});
      // unmapped indexes must be ignored
      if ($urandom_range(2) == 0)
        write_reg(REG_HOLD + CFG_IDX_W'($urandom_range(3, 1)), SAMPLE_W'($urandom));

      for (n = 0; n < 127; n++) begin
        if (sc_phase == PHASE_READ_X && $urandom_range(4) == 0) pressed = !pressed;
        if ($urandom_range(9) == 0) begin
          s = SAMPLE_W'($urandom_range(4095, 0));
        end else begin
          case (sc_phase)
            PHASE_READ_X: s = pick_sample(lim_x_lo, lim_x_hi, pressed);
            PHASE_READ_Y: s = pick_sample(lim_y_lo, lim_y_hi, pressed);
            default: s = SAMPLE_W'($urandom_range(4095, 0));
          endcase
        end
        send_sample(s, 1'b0, '0);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
sv/rts_pkg.sv
sv/resistive_touch_scanner.sv
sv/rts_checker.sv
tb/tb_resistive_touch_scanner.sv
